// ===== rtl/mqm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqm_pkg
// Shared constants and types of the multi-queue mailbox.
// ----------------------------------------------------------------------------
package mqm_pkg;
    localparam int NUM_QUEUES_DEF        = 256;
    localparam int QUEUE_DEPTH_DEF       = 32;
    localparam int MAX_PAYLOAD_BYTES_DEF = 8;

    localparam logic [2:0] CMD_SEND    = 3'd0;
    localparam logic [2:0] CMD_REQUEST = 3'd1;
    localparam logic [2:0] CMD_BCAST   = 3'd2;
    localparam logic [2:0] CMD_RECV    = 3'd3;
    localparam logic [2:0] CMD_STATS   = 3'd4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SIZE  = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [9:0]  task_id;
        logic [9:0]  peer_task;
        logic [63:0] payload;
        logic [7:0]  payload_size;
        logic [63:0] time_stamp;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  out_sender;
        logic [63:0] out_message_id;
        logic [63:0] out_request_id;
        logic        out_type;
        logic [3:0]  out_size;
        logic [63:0] out_payload;
        logic [63:0] out_time;
        logic [31:0] stat_received;
        logic [31:0] stat_dropped;
        logic [31:0] stat_sent;
        logic [31:0] stat_broadcasts;
    } res_t;
endpackage
`default_nettype wire

// ===== rtl/mqm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqm_front
// Accepts command words and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module mqm_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire mqm_pkg::cmd_t in_cmd,
    output logic               q_valid,
    input  wire logic          q_ready,
    output mqm_pkg::cmd_t      q_cmd
);
    import mqm_pkg::*;

    cmd_t       buf_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = buf_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mqm_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqm_engine
// Executes one command: reads queue state, then writes it back and emits.
// ----------------------------------------------------------------------------
module mqm_engine #(
    parameter int NUM_QUEUES        = mqm_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH       = mqm_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_PAYLOAD_BYTES = mqm_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire mqm_pkg::cmd_t q_cmd,
    output logic               res_valid,
    input  wire logic          res_ready,
    output mqm_pkg::res_t      res
);
    import mqm_pkg::*;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = QW + PW;
    localparam int SLOTS = NUM_QUEUES * (1 << PW);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);
    localparam logic [QW-1:0] CLR_LAST = QW'(NUM_QUEUES - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    // per-queue state memories
    logic [PW-1:0] head_mem [NUM_QUEUES];
    logic [PW-1:0] tail_mem [NUM_QUEUES];
    logic [FW-1:0] fill_mem [NUM_QUEUES];
    logic [31:0]   rcv_mem  [NUM_QUEUES];
    logic [31:0]   drp_mem  [NUM_QUEUES];
    logic [31:0]   snt_mem  [NUM_QUEUES];
    logic [31:0]   bc_mem   [NUM_QUEUES];
    // payload, message id, request id, timestamp, size, type, sender
    logic [270:0]  slot_mem [SLOTS];

    logic [1:0]    state_reg;
    logic [QW-1:0] clr_reg;
    cmd_t          cmd_reg;
    logic [63:0]   id_reg;
    res_t          res_reg;
    logic          recv_reg;
    logic [270:0]  slot_rd_reg;

    logic [PW-1:0] p_tail_reg, t_head_reg;
    logic [FW-1:0] p_fill_reg, t_fill_reg;
    logic [31:0]   p_rcv_reg, p_drp_reg, t_rcv_reg, t_drp_reg, t_snt_reg, t_bc_reg;

    logic [QW-1:0] tq_in, pq_in, tq, pq;
    logic [SW-1:0] wr_addr, rd_addr;
    logic          is_send, is_req, t_in, p_in, bad_size, full;
    logic          push_ok, push_full, sent_inc, bc_inc, pop_ok;
    logic [63:0]   mask, id_next;
    logic [270:0]  slot_wr;
    logic [PW-1:0] tail_next, head_next;
    res_t          res_next;

    assign tq_in = q_cmd.task_id[QW-1:0];
    assign pq_in = q_cmd.peer_task[QW-1:0];
    assign tq = cmd_reg.task_id[QW-1:0];
    assign pq = cmd_reg.peer_task[QW-1:0];
    assign wr_addr = {pq, p_tail_reg};
    assign rd_addr = {tq, t_head_reg};
    assign q_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);

    // received message overlays the registered result
    always_comb begin
        res = res_reg;
        if (recv_reg) begin
            res.out_payload    = slot_rd_reg[270:207];
            res.out_message_id = slot_rd_reg[206:143];
            res.out_request_id = slot_rd_reg[142:79];
            res.out_time       = slot_rd_reg[78:15];
            res.out_size       = slot_rd_reg[14:11];
            res.out_type       = slot_rd_reg[10];
            res.out_sender     = slot_rd_reg[9:0];
        end
    end

    // clocked reads: queue state when a command is accepted, message slot in the execute state
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && q_valid) begin
            p_tail_reg <= tail_mem[pq_in];
            p_fill_reg <= fill_mem[pq_in];
            p_rcv_reg  <= rcv_mem[pq_in];
            p_drp_reg  <= drp_mem[pq_in];
            t_head_reg <= head_mem[tq_in];
            t_fill_reg <= fill_mem[tq_in];
            t_rcv_reg  <= rcv_mem[tq_in];
            t_drp_reg  <= drp_mem[tq_in];
            t_snt_reg  <= snt_mem[tq_in];
            t_bc_reg   <= bc_mem[tq_in];
        end
        if (state_reg == S_EXEC) begin
            slot_rd_reg <= slot_mem[rd_addr];
        end
    end

    always_comb begin
        is_send  = (cmd_reg.command == CMD_SEND);
        is_req   = (cmd_reg.command == CMD_REQUEST);
        t_in     = (cmd_reg.task_id < 10'(NUM_QUEUES)) || (NUM_QUEUES >= 1024);
        p_in     = (cmd_reg.peer_task < 10'(NUM_QUEUES)) || (NUM_QUEUES >= 1024);
        bad_size = cmd_reg.payload_size > 8'(MAX_PAYLOAD_BYTES);
        full     = (p_fill_reg >= FILL_MAX);
        push_ok   = (is_send || is_req) && !bad_size && p_in && !full;
        push_full = (is_send || is_req) && !bad_size && p_in && full;
        sent_inc  = is_send && push_ok && t_in;
        bc_inc    = (cmd_reg.command == CMD_BCAST) && !bad_size && t_in;
        pop_ok    = (cmd_reg.command == CMD_RECV) && t_in && (t_fill_reg != '0);
        if (cmd_reg.payload_size >= 8'd8) mask = '1;
        else mask = (64'd1 << {cmd_reg.payload_size[2:0], 3'b000}) - 64'd1;
        slot_wr = {cmd_reg.payload & mask,
                   is_req ? id_reg + 64'd1 : id_reg,
                   is_req ? id_reg : 64'd0,
                   cmd_reg.time_stamp,
                   cmd_reg.payload_size[3:0],
                   is_req,
                   cmd_reg.task_id};
        tail_next = (p_tail_reg == PTR_LAST) ? '0 : p_tail_reg + PW'(1);
        head_next = (t_head_reg == PTR_LAST) ? '0 : t_head_reg + PW'(1);
        id_next = id_reg;
        res_next = '0;
        case (cmd_reg.command)
            CMD_SEND, CMD_REQUEST: begin
                if (bad_size) begin
                    res_next.status = ST_SIZE;
                end else begin
                    id_next = id_reg + (is_req ? 64'd2 : 64'd1);
                    if (!p_in) begin
                        res_next.status = ST_RANGE;
                    end else if (full) begin
                        res_next.status = ST_FULL;
                    end else if (is_req) begin
                        res_next.out_request_id = id_reg;
                    end
                end
            end
            CMD_BCAST: begin
                if (bad_size) begin
                    res_next.status = ST_SIZE;
                end else begin
                    id_next = id_reg + 64'd1;
                end
            end
            CMD_RECV: begin
                if (!t_in) begin
                    res_next.status = ST_RANGE;
                end else if (t_fill_reg == '0) begin
                    res_next.status = ST_EMPTY;
                end
            end
            CMD_STATS: begin
                if (!t_in) begin
                    res_next.status = ST_RANGE;
                end else begin
                    res_next.status = (t_fill_reg != '0) ? ST_OK : ST_EMPTY;
                    res_next.stat_received   = t_rcv_reg;
                    res_next.stat_dropped    = t_drp_reg;
                    res_next.stat_sent       = t_snt_reg;
                    res_next.stat_broadcasts = t_bc_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // memory writes: clearing pass after reset, then one update per command
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            head_mem[clr_reg] <= '0;
            tail_mem[clr_reg] <= '0;
            fill_mem[clr_reg] <= '0;
            rcv_mem[clr_reg]  <= '0;
            drp_mem[clr_reg]  <= '0;
            snt_mem[clr_reg]  <= '0;
            bc_mem[clr_reg]   <= '0;
        end
        if (state_reg == S_EXEC) begin
            if (push_ok) begin
                slot_mem[wr_addr] <= slot_wr;
                tail_mem[pq]      <= tail_next;
                fill_mem[pq]      <= p_fill_reg + FW'(1);
                rcv_mem[pq]       <= p_rcv_reg + 32'd1;
            end
            if (push_full) drp_mem[pq] <= p_drp_reg + 32'd1;
            if (sent_inc)  snt_mem[tq] <= t_snt_reg + 32'd1;
            if (bc_inc)    bc_mem[tq]  <= t_bc_reg + 32'd1;
            if (pop_ok) begin
                head_mem[tq] <= head_next;
                fill_mem[tq] <= t_fill_reg - FW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            id_reg    <= 64'd1;
            res_reg   <= '0;
            recv_reg  <= 1'b0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    if (clr_reg == CLR_LAST) state_reg <= S_IDLE;
                    clr_reg <= clr_reg + QW'(1);
                end
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg   <= q_cmd;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    res_reg   <= res_next;
                    recv_reg  <= pop_ok;
                    id_reg    <= id_next;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (res_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/multi_queue_mailbox.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_mailbox
// Mailbox with one circular message queue per task.
// ----------------------------------------------------------------------------
// After reset the engine walks all NUM_QUEUES queues (256 by default), clearing
// the per-queue pointers and counters; meanwhile only the two-word front queue
// takes commands. Each command word then passes the engine in three steps:
// reading the queue pointers and counters; updating them, reading the message
// slot and forming the result; and handing the result out, held while the
// receiver stalls. The front queue keeps accepting commands meanwhile, until
// it holds two words.
module multi_queue_mailbox #(
    parameter int NUM_QUEUES        = mqm_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH       = mqm_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_PAYLOAD_BYTES = mqm_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // command, task_id, peer_task, payload, payload_size, time_stamp, pad
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, out_sender, out_message_id, out_request_id, out_type, out_size,
    // out_payload, out_time, stat_received, stat_dropped, stat_sent,
    // stat_broadcasts, pad
    output logic [407:0]      m_tdata
);
    import mqm_pkg::*;

    cmd_t in_cmd, q_cmd;
    res_t res;
    logic q_valid, q_ready;

    assign in_cmd.command      = s_tdata[2:0];
    assign in_cmd.task_id      = s_tdata[12:3];
    assign in_cmd.peer_task    = s_tdata[22:13];
    assign in_cmd.payload      = s_tdata[86:23];
    assign in_cmd.payload_size = s_tdata[94:87];
    assign in_cmd.time_stamp   = s_tdata[158:95];

    assign m_tdata = {6'd0, res.stat_broadcasts, res.stat_sent, res.stat_dropped,
                      res.stat_received, res.out_time, res.out_payload, res.out_size,
                      res.out_type, res.out_request_id, res.out_message_id,
                      res.out_sender, res.status};

    mqm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    mqm_engine #(
        .NUM_QUEUES(NUM_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );
endmodule
`default_nettype wire

// ===== tb/multi_queue_mailbox_checker.sv =====
// ----------------------------------------------------------------------------
// multi_queue_mailbox_checker
// Watches both channels of the mailbox. Keeps its own copy of every queue and
// counter, works out the result of each accepted command word and compares it
// field by field with the next result word that leaves the block.
// ----------------------------------------------------------------------------
module multi_queue_mailbox_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [159:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [407:0] m_tdata,
    output int           fails,
    output int           pending
);
    import mqm_pkg::*;

    localparam int NQ    = NUM_QUEUES_DEF;
    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int MAXB  = MAX_PAYLOAD_BYTES_DEF;

    logic [63:0] mb_payload [NQ*DEPTH];
    logic [63:0] mb_ident   [NQ*DEPTH];
    logic [63:0] mb_request [NQ*DEPTH];
    logic [63:0] mb_time    [NQ*DEPTH];
    logic [9:0]  mb_sender  [NQ*DEPTH];
    logic        mb_type    [NQ*DEPTH];
    logic [3:0]  mb_size    [NQ*DEPTH];
    int          q_head [NQ];
    int          q_tail [NQ];
    int          q_fill [NQ];
    logic [31:0] cnt_recv  [NQ];
    logic [31:0] cnt_drop  [NQ];
    logic [31:0] cnt_sent  [NQ];
    logic [31:0] cnt_bcast [NQ];
    logic [63:0] next_id;

    res_t expected_words[$];

    initial pending = 0;

    // returns status of delivering into queue dst
    function automatic logic [2:0] deliver(input logic [9:0] dst, input logic [9:0] src,
                                           input logic kind, input logic [63:0] mid,
                                           input logic [63:0] rid, input logic [63:0] data,
                                           input logic [7:0] size, input logic [63:0] ts);
        int s;
        logic [63:0] mask;
        if (dst >= NQ) return ST_RANGE;
        if (q_fill[dst] >= DEPTH) begin
            cnt_drop[dst] = cnt_drop[dst] + 1;
            return ST_FULL;
        end
        mask = (size >= 8) ? '1 : ((64'd1 << (size * 8)) - 64'd1);
        s = dst * DEPTH + q_tail[dst];
        mb_payload[s] = data & mask;
        mb_ident[s]   = mid;
        mb_request[s] = rid;
        mb_time[s]    = ts;
        mb_sender[s]  = src;
        mb_type[s]    = kind;
        mb_size[s]    = size[3:0];
        q_tail[dst] = (q_tail[dst] + 1 >= DEPTH) ? 0 : q_tail[dst] + 1;
        q_fill[dst]++;
        cnt_recv[dst] = cnt_recv[dst] + 1;
        return ST_OK;
    endfunction

    function automatic res_t mailbox_result(input logic [159:0] w);
        logic [2:0]  cmd;
        logic [9:0]  tsk, peer;
        logic [63:0] data, ts, rid, mid;
        logic [7:0]  size;
        logic        bad;
        int          s;
        res_t        r;
        cmd  = w[2:0];
        tsk  = w[12:3];
        peer = w[22:13];
        data = w[86:23];
        size = w[94:87];
        ts   = w[158:95];
        bad  = size > MAXB;
        r = '0;
        case (cmd)
            CMD_SEND: begin
                if (bad) r.status = ST_SIZE;
                else begin
                    mid = next_id;
                    next_id = next_id + 1;
                    r.status = deliver(peer, tsk, 1'b0, mid, 64'd0, data, size, ts);
                    if (r.status == ST_OK && tsk < NQ) cnt_sent[tsk] = cnt_sent[tsk] + 1;
                end
            end
            CMD_REQUEST: begin
                if (bad) r.status = ST_SIZE;
                else begin
                    rid = next_id;
                    mid = next_id + 1;
                    next_id = next_id + 2;
                    r.status = deliver(peer, tsk, 1'b1, mid, rid, data, size, ts);
                    if (r.status == ST_OK) r.out_request_id = rid;
                end
            end
            CMD_BCAST: begin
                if (bad) r.status = ST_SIZE;
                else begin
                    next_id = next_id + 1;
                    if (tsk < NQ) cnt_bcast[tsk] = cnt_bcast[tsk] + 1;
                end
            end
            CMD_RECV: begin
                if (tsk >= NQ) r.status = ST_RANGE;
                else if (q_fill[tsk] == 0) r.status = ST_EMPTY;
                else begin
                    s = tsk * DEPTH + q_head[tsk];
                    r.out_sender     = mb_sender[s];
                    r.out_message_id = mb_ident[s];
                    r.out_request_id = mb_request[s];
                    r.out_type       = mb_type[s];
                    r.out_size       = mb_size[s];
                    r.out_payload    = mb_payload[s];
                    r.out_time       = mb_time[s];
                    q_head[tsk] = (q_head[tsk] + 1 >= DEPTH) ? 0 : q_head[tsk] + 1;
                    q_fill[tsk]--;
                end
            end
            CMD_STATS: begin
                if (tsk >= NQ) r.status = ST_RANGE;
                else begin
                    r.stat_received   = cnt_recv[tsk];
                    r.stat_dropped    = cnt_drop[tsk];
                    r.stat_sent       = cnt_sent[tsk];
                    r.stat_broadcasts = cnt_bcast[tsk];
                    r.status = (q_fill[tsk] > 0) ? ST_OK : ST_EMPTY;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic res_t unpack_word(input logic [407:0] w);
        res_t r;
        r.status          = w[2:0];
        r.out_sender      = w[12:3];
        r.out_message_id  = w[76:13];
        r.out_request_id  = w[140:77];
        r.out_type        = w[141];
        r.out_size        = w[145:142];
        r.out_payload     = w[209:146];
        r.out_time        = w[273:210];
        r.stat_received   = w[305:274];
        r.stat_dropped    = w[337:306];
        r.stat_sent       = w[369:338];
        r.stat_broadcasts = w[401:370];
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t exp_w, got_w;
        if (!aresetn) begin
            for (int i = 0; i < NQ; i++) begin
                q_head[i] = 0;
                q_tail[i] = 0;
                q_fill[i] = 0;
                cnt_recv[i] = '0;
                cnt_drop[i] = '0;
                cnt_sent[i] = '0;
                cnt_bcast[i] = '0;
            end
            next_id = 64'd1;
            expected_words.delete();
            fails = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_words.push_back(mailbox_result(s_tdata));
            if (m_tvalid && m_tready) begin
                got_w = unpack_word(m_tdata);
                if (expected_words.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result word %p", got_w);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got_w.status !== exp_w.status
                        || got_w.out_sender !== exp_w.out_sender
                        || got_w.out_message_id !== exp_w.out_message_id
                        || got_w.out_request_id !== exp_w.out_request_id
                        || got_w.out_type !== exp_w.out_type
                        || got_w.out_size !== exp_w.out_size
                        || got_w.out_payload !== exp_w.out_payload
                        || got_w.out_time !== exp_w.out_time
                        || got_w.stat_received !== exp_w.stat_received
                        || got_w.stat_dropped !== exp_w.stat_dropped
                        || got_w.stat_sent !== exp_w.stat_sent
                        || got_w.stat_broadcasts !== exp_w.stat_broadcasts) begin
                        fails++;
                        if (fails <= 10) $display("mismatch\n  exp %p\n  got %p", exp_w, got_w);
                    end
                end
            end
        end
        pending = expected_words.size();
    end
endmodule

// ===== tb/multi_queue_mailbox_test.sv =====
// ----------------------------------------------------------------------------
// multi_queue_mailbox_test
// Drives directed and random command words into the mailbox under changing
// idle and stall patterns, including one long receiver hold-off, and reports
// the verdict of the checker.
// ----------------------------------------------------------------------------
module multi_queue_mailbox_test;
    import mqm_pkg::*;

    localparam int N_RANDOM = 1200;
    localparam int LIMIT    = 300000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [407:0] m_tdata;
    int           fails, pending;
    int           cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         hold_req = 1'b0;

    always #6 aclk = ~aclk;

    multi_queue_mailbox dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    multi_queue_mailbox_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fails(fails), .pending(pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("multi_queue_mailbox_test: errors");
            $finish;
        end
    end

    // receiver side
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req <= 1'b0;
            end
            m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input logic [2:0] cmd, input logic [9:0] tsk,
                             input logic [9:0] peer, input logic [63:0] data,
                             input logic [7:0] size, input logic [63:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ts, size, data, peer, tsk, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [9:0] pick_task();
        int r;
        r = $urandom_range(99);
        if (r < 85) return 10'($urandom_range(3));
        if (r < 95) return 10'($urandom_range(255));
        return 10'($urandom_range(1023, 256));
    endfunction

    function automatic logic [2:0] pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 30) return CMD_SEND;
        if (r < 45) return CMD_REQUEST;
        if (r < 55) return CMD_BCAST;
        if (r < 85) return CMD_RECV;
        if (r < 95) return CMD_STATS;
        return 3'($urandom_range(7, 5));
    endfunction

    initial begin
        logic [63:0] all1;
        all1 = '1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(CMD_RECV,    10'd5,    10'd0,    64'd0, 8'd0,   64'd0);
        send_word(CMD_STATS,   10'd5,    10'd0,    64'd0, 8'd0,   64'd0);
        send_word(CMD_SEND,    10'd1,    10'd5,    all1,  8'd0,   all1);
        send_word(CMD_SEND,    10'd1023, 10'd5,    all1,  8'd3,   64'd7);
        send_word(CMD_SEND,    10'd2,    10'd5,    all1,  8'd8,   64'd9);
        send_word(CMD_SEND,    10'd2,    10'd5,    all1,  8'd9,   64'd1);
        send_word(CMD_REQUEST, 10'd3,    10'd5,    all1,  8'd255, 64'd1);
        send_word(CMD_REQUEST, 10'd3,    10'd5,    64'h0123456789abcdef, 8'd5, all1);
        send_word(CMD_SEND,    10'd3,    10'd1023, all1,  8'd1,   64'd2);
        send_word(CMD_REQUEST, 10'd3,    10'd256,  all1,  8'd1,   64'd2);
        send_word(CMD_BCAST,   10'd2,    10'd0,    all1,  8'd8,   64'd0);
        send_word(CMD_BCAST,   10'd1023, 10'd0,    all1,  8'd4,   64'd0);
        send_word(CMD_BCAST,   10'd2,    10'd0,    all1,  8'd200, 64'd0);
        send_word(CMD_STATS,   10'd5,    10'd0,    64'd0, 8'd0,   64'd0);
        send_word(CMD_STATS,   10'd2,    10'd0,    64'd0, 8'd0,   64'd0);
        send_word(CMD_STATS,   10'd1023, 10'd0,    64'd0, 8'd0,   64'd0);
        send_word(CMD_RECV,    10'd300,  10'd0,    64'd0, 8'd0,   64'd0);
        repeat (4) send_word(CMD_RECV, 10'd5, 10'd0, 64'd0, 8'd0, 64'd0);
        send_word(3'd5, 10'd5, 10'd5, all1, 8'd1, all1);
        send_word(3'd7, 10'd0, 10'd0, 64'd0, 8'd0, 64'd0);

        for (int i = 0; i < N_RANDOM; i++) begin
            case (i * 4 / N_RANDOM)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (i == 100) hold_req <= 1'b1;
            send_word(pick_cmd(), pick_task(), pick_task(), {$urandom, $urandom},
                      ($urandom_range(99) < 80) ? 8'($urandom_range(8))
                                                : 8'($urandom_range(255, 9)),
                      {$urandom, $urandom});
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fails == 0 && pending == 0)
            $display("multi_queue_mailbox_test: clean");
        else
            $display("multi_queue_mailbox_test: errors");
        $finish;
    end
endmodule
